FILE: hw/rtl/planar_odometry_integrator_top_assert.svh
// Assertion macros used by the odometry integrator checker.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PODO_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PODO_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/podo_pkg.sv
// Shared constants, types and the quarter-wave sine table of the odometry integrator.
`default_nettype none

package podo_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int POS_WIDTH        = 48;

  localparam int ANG_W      = 16;   // binary angles and 16-bit fields
  localparam int STAMP_W    = 32;
  localparam int OUT_POS_W  = 48;
  localparam int MAG_W      = 15;   // sine magnitude, 0..32767
  localparam int ROT_W      = 33;   // rotated velocity, 2^-15 mm/s
  localparam int FRAC_SHIFT = 15;
  localparam int PROD_W     = ROT_W + 1 + STAMP_W;
  localparam int DELTA_W    = PROD_W - FRAC_SHIFT;
  localparam int SUM_W      = ((POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W) + 1;
  localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TAB_AW     = $clog2(SINE_TABLE_DEPTH);
  localparam int CNT_W      = $clog2(STAMP_W);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // (2k)(2k+1) divisors of the Taylor terms, entry zero unused
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                             64'd72, 64'd110, 64'd156, 64'd210};

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t sine_tab_t [SINE_TABLE_DEPTH];

  typedef struct packed {
    logic load;
    logic step;
  } podo_ctl_t;

  typedef struct packed {
    logic sin_neg;
    mag_t sin_mag;
    logic cos_neg;
    mag_t cos_mag;
  } trig_t;

  // round(32767 * sin(i/DEPTH * pi/2)) in Q30 integer arithmetic
  function automatic mag_t quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] e;
    longint      s;
    int          k;
    x  = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[k];
      if (k[0]) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    e = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[MAG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    int        i;
    for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam mag_t      SINE_TOP = quarter_sine(SINE_TABLE_DEPTH);

endpackage

`default_nettype wire

FILE: hw/rtl/podo_sincos.sv
// Registered sine and cosine lookup of the current heading.
`default_nettype none

module podo_sincos (
  input  logic                         clk_i,
  input  logic [podo_pkg::ANG_W-1:0]   heading_i,
  output podo_pkg::trig_t              trig_o
);

  localparam int PW = podo_pkg::ANG_W - 2 + podo_pkg::IDX_W;
  localparam logic [podo_pkg::ANG_W-1:0] QUARTER = podo_pkg::ANG_W'(1 << (podo_pkg::ANG_W - 2));

  // returns {negative, magnitude}
  function automatic logic [podo_pkg::MAG_W:0] lookup(input logic [podo_pkg::ANG_W-1:0] h);
    logic [PW-1:0]               prod;
    logic [podo_pkg::IDX_W-1:0]  idx;
    logic [podo_pkg::IDX_W-1:0]  j;
    podo_pkg::mag_t              mag;
    prod = PW'(h[podo_pkg::ANG_W-3:0]) * PW'(podo_pkg::SINE_TABLE_DEPTH);
    idx  = prod[podo_pkg::ANG_W-2 +: podo_pkg::IDX_W];
    j    = h[podo_pkg::ANG_W-2] ? podo_pkg::IDX_W'(podo_pkg::SINE_TABLE_DEPTH) - idx : idx;
    mag  = (j == podo_pkg::IDX_W'(podo_pkg::SINE_TABLE_DEPTH)) ? podo_pkg::SINE_TOP
         : podo_pkg::SINE_TAB[j[podo_pkg::TAB_AW-1:0]];
    return {h[podo_pkg::ANG_W-1], mag};
  endfunction

  podo_pkg::trig_t trig_d;

  always_comb begin
    {trig_d.sin_neg, trig_d.sin_mag} = lookup(heading_i);
    {trig_d.cos_neg, trig_d.cos_mag} = lookup(heading_i + QUARTER);
  end

  // tracks the heading register in the following cycle
  always_ff @(posedge clk_i) begin
    trig_o <= trig_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/podo_rot.sv
// Bit-serial rotation of the body velocity into the world frame, MSB of sin/cos first.
`default_nettype none

module podo_rot (
  input  logic                                clk_i,
  input  podo_pkg::podo_ctl_t                 ctl_i,
  input  podo_pkg::trig_t                     trig_i,
  input  logic signed [podo_pkg::ANG_W-1:0]   vx_i,
  input  logic signed [podo_pkg::ANG_W-1:0]   vy_i,
  output logic signed [podo_pkg::ROT_W-1:0]   rx_o,
  output logic signed [podo_pkg::ROT_W-1:0]   ry_o
);

  logic signed [podo_pkg::ANG_W-1:0] vx_q, vy_q;
  logic                              cneg_q, sneg_q;
  podo_pkg::mag_t                    cmag_q, smag_q;
  logic signed [podo_pkg::ROT_W-1:0] rx_q, ry_q, rx_d, ry_d;
  logic signed [podo_pkg::ROT_W-1:0] vx_e, vy_e, vxc, vxs, vyc, vys;

  always_comb begin
    vx_e = podo_pkg::ROT_W'(vx_q);
    vy_e = podo_pkg::ROT_W'(vy_q);
    vxc  = cneg_q ? -vx_e : vx_e;
    vyc  = cneg_q ? -vy_e : vy_e;
    vxs  = sneg_q ? -vx_e : vx_e;
    vys  = sneg_q ? -vy_e : vy_e;
    // rx = vx*cos - vy*sin, ry = vx*sin + vy*cos
    rx_d = (rx_q <<< 1) + (cmag_q[podo_pkg::MAG_W-1] ? vxc : '0)
                        - (smag_q[podo_pkg::MAG_W-1] ? vys : '0);
    ry_d = (ry_q <<< 1) + (smag_q[podo_pkg::MAG_W-1] ? vxs : '0)
                        + (cmag_q[podo_pkg::MAG_W-1] ? vyc : '0);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      vx_q   <= vx_i;
      vy_q   <= vy_i;
      cneg_q <= trig_i.cos_neg;
      sneg_q <= trig_i.sin_neg;
      cmag_q <= trig_i.cos_mag;
      smag_q <= trig_i.sin_mag;
      rx_q   <= '0;
      ry_q   <= '0;
    end else if (ctl_i.step) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      cmag_q <= {cmag_q[podo_pkg::MAG_W-2:0], 1'b0};
      smag_q <= {smag_q[podo_pkg::MAG_W-2:0], 1'b0};
    end
  end

  assign rx_o = rx_q;
  assign ry_o = ry_q;

endmodule

`default_nettype wire

FILE: hw/rtl/podo_smul.sv
// Bit-serial signed-by-unsigned multiplier, one dt bit per cycle while step is high, LSB first.
`default_nettype none

module podo_smul (
  input  logic                                  clk_i,
  input  podo_pkg::podo_ctl_t                   ctl_i,
  input  logic signed [podo_pkg::ROT_W-1:0]     a_i,
  input  logic [podo_pkg::STAMP_W-1:0]          b_i,
  output logic signed [podo_pkg::DELTA_W-1:0]   delta_o
);

  logic signed [podo_pkg::ROT_W-1:0] a_q;
  logic [podo_pkg::STAMP_W-1:0]      b_q, b_d;
  logic signed [podo_pkg::ROT_W:0]   p_q, p_d, sum;
  logic [podo_pkg::PROD_W-1:0]       prod;

  always_comb begin
    sum = p_q + (b_q[0] ? (podo_pkg::ROT_W + 1)'(a_q) : '0);
    p_d = sum >>> 1;
    // low product bits replace the multiplier bits as they are consumed
    b_d = {sum[0], b_q[podo_pkg::STAMP_W-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (ctl_i.step) begin
      p_q <= p_d;
      b_q <= b_d;
    end
  end

  // arithmetic shift right by 15 = floor division
  assign prod    = {p_q, b_q};
  assign delta_o = prod[podo_pkg::PROD_W-1:podo_pkg::FRAC_SHIFT];

endmodule

`default_nettype wire

FILE: hw/rtl/planar_odometry_integrator_top.sv
// Top level of the planar dead-reckoning odometry integrator.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-----------------------------------------------
//   in      | in_valid_i  | in_stall_o   | func, time_stamp, velocity_x/y, yaw_angle/rate
//   out     | out_valid_o | out_stall_i  | pos_x/y, heading, vel_x/y, rate_out
//
// Velocity sample: from transfer to the next possible input transfer it passes 15 rotator
// steps (one sine/cosine bit each), 32 multiplier steps (one dt bit each), then the load,
// saturate and result stages. Heading sample: the result stage only.
// One item is in work at a time; the result register lets the next item start while a
// result waits on out_stall_i. Reset clears pose, heading and held values to zero.
`default_nettype none

module planar_odometry_integrator_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    func_i,
  input  logic [podo_pkg::STAMP_W-1:0]            time_stamp_i,
  input  logic signed [podo_pkg::ANG_W-1:0]       velocity_x_i,
  input  logic signed [podo_pkg::ANG_W-1:0]       velocity_y_i,
  input  logic signed [podo_pkg::ANG_W-1:0]       yaw_angle_i,
  input  logic signed [podo_pkg::ANG_W-1:0]       yaw_rate_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [podo_pkg::OUT_POS_W-1:0]   pos_x_o,
  output logic signed [podo_pkg::OUT_POS_W-1:0]   pos_y_o,
  output logic signed [podo_pkg::ANG_W-1:0]       heading_o,
  output logic signed [podo_pkg::ANG_W-1:0]       vel_x_o,
  output logic signed [podo_pkg::ANG_W-1:0]       vel_y_o,
  output logic signed [podo_pkg::ANG_W-1:0]       rate_out_o
);

  localparam int PW    = podo_pkg::POS_WIDTH;
  localparam int SW    = podo_pkg::SUM_W;
  localparam int CW    = podo_pkg::CNT_W;
  localparam int EXT_W = (PW > podo_pkg::OUT_POS_W) ? PW : podo_pkg::OUT_POS_W;

  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [SW-1:0] SUM_HI  = SW'(POS_MAX);
  localparam logic signed [SW-1:0] SUM_LO  = SW'(POS_MIN);

  localparam logic [CW-1:0] ROT_LAST = CW'(podo_pkg::MAG_W - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(podo_pkg::STAMP_W - 1);

  localparam logic FUNC_VEL = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROT  = 6'b000010,
    ST_MLD  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SAT  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic signed [PW-1:0]              acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  logic [podo_pkg::ANG_W-1:0]        cur_heading_q, heading_zero_q, zero_n;
  logic                              zero_latched_q;
  logic [podo_pkg::STAMP_W-1:0]      prev_stamp_q, dt_q;
  logic signed [podo_pkg::ANG_W-1:0] held_vx_q, held_vy_q, held_rate_q;

  logic                                     out_valid_q;
  logic signed [podo_pkg::OUT_POS_W-1:0]    out_x_q, out_y_q;
  logic signed [podo_pkg::ANG_W-1:0]        out_hd_q, out_vx_q, out_vy_q, out_rate_q;
  logic signed [EXT_W-1:0]                  ext_x, ext_y;

  logic in_fire, out_free, out_load;
  podo_pkg::podo_ctl_t rot_ctl, mul_ctl;
  podo_pkg::trig_t     trig;
  logic signed [podo_pkg::ROT_W-1:0]   rx, ry;
  logic signed [podo_pkg::DELTA_W-1:0] dx, dy;
  logic signed [SW-1:0]                sum_x, sum_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_OUT) && out_free;

  assign rot_ctl.load = in_fire && (func_i == FUNC_VEL);
  assign rot_ctl.step = (state_q == ST_ROT);
  assign mul_ctl.load = (state_q == ST_MLD);
  assign mul_ctl.step = (state_q == ST_MUL);

  // trig registers follow cur_heading in the next cycle; a heading update always passes the
  // result stage first, so trig is current when the next velocity transfer loads the rotator
  podo_sincos u_sincos (
    .clk_i     (clk_i),
    .heading_i (cur_heading_q),
    .trig_o    (trig)
  );

  podo_rot u_rot (
    .clk_i  (clk_i),
    .ctl_i  (rot_ctl),
    .trig_i (trig),
    .vx_i   (velocity_x_i),
    .vy_i   (velocity_y_i),
    .rx_o   (rx),
    .ry_o   (ry)
  );

  podo_smul u_mul_x (
    .clk_i   (clk_i),
    .ctl_i   (mul_ctl),
    .a_i     (rx),
    .b_i     (dt_q),
    .delta_o (dx)
  );

  podo_smul u_mul_y (
    .clk_i   (clk_i),
    .ctl_i   (mul_ctl),
    .a_i     (ry),
    .b_i     (dt_q),
    .delta_o (dy)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          state_d = (func_i == FUNC_VEL) ? ST_ROT : ST_OUT;
        end
      end
      ST_ROT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROT_LAST) begin
          state_d = ST_MLD;
        end
      end
      ST_MLD: begin
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    zero_n  = zero_latched_q ? heading_zero_q : yaw_angle_i;
    sum_x   = SW'(acc_x_q) + SW'(dx);
    sum_y   = SW'(acc_y_q) + SW'(dy);
    acc_x_d = (sum_x > SUM_HI) ? POS_MAX : (sum_x < SUM_LO) ? POS_MIN : sum_x[PW-1:0];
    acc_y_d = (sum_y > SUM_HI) ? POS_MAX : (sum_y < SUM_LO) ? POS_MIN : sum_y[PW-1:0];
    ext_x   = EXT_W'(acc_x_q);
    ext_y   = EXT_W'(acc_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      acc_x_q        <= '0;
      acc_y_q        <= '0;
      cur_heading_q  <= '0;
      heading_zero_q <= '0;
      zero_latched_q <= 1'b0;
      prev_stamp_q   <= '0;
      dt_q           <= '0;
      held_vx_q      <= '0;
      held_vy_q      <= '0;
      held_rate_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_fire) begin
        if (func_i == FUNC_VEL) begin
          dt_q         <= time_stamp_i - prev_stamp_q;
          prev_stamp_q <= time_stamp_i;
          held_vx_q    <= velocity_x_i;
          held_vy_q    <= velocity_y_i;
        end else begin
          zero_latched_q <= 1'b1;
          heading_zero_q <= zero_n;
          cur_heading_q  <= zero_n - yaw_angle_i;
          held_rate_q    <= yaw_rate_i;
        end
      end
      if (state_q == ST_SAT) begin
        acc_x_q <= acc_x_d;
        acc_y_q <= acc_y_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= ext_x[podo_pkg::OUT_POS_W-1:0];
      out_y_q    <= ext_y[podo_pkg::OUT_POS_W-1:0];
      out_hd_q   <= cur_heading_q;
      out_vx_q   <= held_vx_q;
      out_vy_q   <= held_vy_q;
      out_rate_q <= held_rate_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_hd_q;
  assign vel_x_o     = out_vx_q;
  assign vel_y_o     = out_vy_q;
  assign rate_out_o  = out_rate_q;

endmodule

`default_nettype wire

FILE: hw/rtl/podo_chk.sv
// Port-level checker for the odometry integrator, bound to the top level.
`default_nettype none

`include "planar_odometry_integrator_top_assert.svh"

module podo_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  func_i,
  input logic [podo_pkg::STAMP_W-1:0]          time_stamp_i,
  input logic signed [podo_pkg::ANG_W-1:0]     velocity_x_i,
  input logic signed [podo_pkg::ANG_W-1:0]     velocity_y_i,
  input logic signed [podo_pkg::ANG_W-1:0]     yaw_angle_i,
  input logic signed [podo_pkg::ANG_W-1:0]     yaw_rate_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [podo_pkg::OUT_POS_W-1:0] pos_x_o,
  input logic signed [podo_pkg::OUT_POS_W-1:0] pos_y_o,
  input logic signed [podo_pkg::ANG_W-1:0]     heading_o,
  input logic signed [podo_pkg::ANG_W-1:0]     vel_x_o,
  input logic signed [podo_pkg::ANG_W-1:0]     vel_y_o,
  input logic signed [podo_pkg::ANG_W-1:0]     rate_out_o
);

  // stalled result stays up
  `PODO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // stalled result payload frozen
  `PODO_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(pos_x_o) && $stable(pos_y_o) && $stable(heading_o) && $stable(vel_x_o) && $stable(vel_y_o) && $stable(rate_out_o), "result payload changed under stall")

  // one item at a time: a transfer makes the block busy
  `PODO_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken without going busy")

  // idle with nothing pending cannot produce a result
  `PODO_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !in_stall_o && !in_valid_i && !out_valid_o, !out_valid_o, "result without an input transfer")

endmodule

bind planar_odometry_integrator_top podo_chk u_podo_chk (.*);

`default_nettype wire
